// ----- rtl/ffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 32;
	localparam int ADDR_W       = $clog2(HEAP_BYTES);
	localparam int PTR_W        = ADDR_W + 1;
	localparam int SUM_W        = PTR_W + 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(HEAP_BYTES);

	localparam logic [0:0] OP_ALLOC = 1'b0;
	localparam logic [0:0] OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_BAD_FREE  = 2'd2;

	typedef struct packed {
		logic [0:0]        opcode;
		logic [11:0]       request_bytes;
		logic [11:0]       data_address;
	} ffa_in_t;

	typedef struct packed {
		logic [11:0] result_address;
		logic [1:0]  status;
	} ffa_out_t;

	typedef struct packed {
		logic             busy;
		logic [11:0]      size;
		logic [PTR_W-1:0] next_free;
		logic [PTR_W-1:0] next_busy;
	} ffa_hdr_t;

	localparam int HDR_W = $bits(ffa_hdr_t);

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_READ_CUR,
		DP_READ_NXT,
		DP_A_ADVANCE,
		DP_A_UNLINK,
		DP_A_PUSH,
		DP_A_CARVE,
		DP_F_ADVANCE,
		DP_F_UNLINK,
		DP_F_PUSH,
		DP_M_MERGE,
		DP_M_ADVANCE,
		DP_FAIL,
		DP_F_DONE
	} ffa_dp_op_t;

	typedef struct packed {
		ffa_dp_op_t op;
	} ffa_cmd_t;

	typedef struct packed {
		logic cur_null;
		logic nxt_null;
		logic fit;
		logic hit;
		logic adj;
		logic addr_bad;
	} ffa_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_CHK,
		S_A_EVAL,
		S_A_PUSH,
		S_A_CARVE,
		S_F_CHK,
		S_F_EVAL,
		S_F_PUSH,
		S_M_CHK,
		S_M_EVAL
	} ffa_state_t;

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with busy/free header lists kept in one RAM.
// ----------------------------------------------------------------------------
// Alloc walks the free list to the first fitting block, else carves at the
// heap top or reports exhaustion; free walks the busy list to the hit block,
// then merges; a bad free stops the walk. Each list step reads the header RAM.
// Throughput: one beat at a time; busy is high for the whole walk.
// Reset: arst_n clears list heads to null and heap top to zero; header RAM
// contents are undefined until written. done pulses one cycle per result.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ffa_pkg::ffa_in_t  request,
	output logic              busy,
	output logic              done,
	output ffa_pkg::ffa_out_t response
);
	import ffa_pkg::*;

	ffa_cmd_t  cmd;
	ffa_stat_t stat;

	// Sequencer: decodes the beat and steps through the list walks.
	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: pointers, header RAM, merge arithmetic and result beat.
	ffa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.stat     (stat),
		.done     (done),
		.response (response)
	);

endmodule

// ----- rtl/ffa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate, free and merge list walks.
// ----------------------------------------------------------------------------
module ffa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [0:0]         opcode,
	input  ffa_pkg::ffa_stat_t stat,
	output ffa_pkg::ffa_cmd_t  cmd,
	output logic               busy
);
	import ffa_pkg::*;

	ffa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = DP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = DP_LOAD;
					state_d = (opcode == OP_FREE) ? S_F_CHK : S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.cur_null) begin
					state_d = S_A_CARVE;
				end else begin
					cmd.op  = DP_READ_CUR;
					state_d = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				if (stat.fit) begin
					cmd.op  = DP_A_UNLINK;
					state_d = S_A_PUSH;
				end else begin
					cmd.op  = DP_A_ADVANCE;
					state_d = S_A_CHK;
				end
			end
			S_A_PUSH: begin
				cmd.op  = DP_A_PUSH;
				state_d = S_IDLE;
			end
			S_A_CARVE: begin
				cmd.op  = DP_A_CARVE;
				state_d = S_IDLE;
			end
			S_F_CHK: begin
				if (stat.addr_bad || stat.cur_null) begin
					cmd.op  = DP_FAIL;
					state_d = S_IDLE;
				end else begin
					cmd.op  = DP_READ_CUR;
					state_d = S_F_EVAL;
				end
			end
			S_F_EVAL: begin
				if (stat.hit) begin
					cmd.op  = DP_F_UNLINK;
					state_d = S_F_PUSH;
				end else begin
					cmd.op  = DP_F_ADVANCE;
					state_d = S_F_CHK;
				end
			end
			S_F_PUSH: begin
				cmd.op  = DP_F_PUSH;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				if (stat.nxt_null) begin
					cmd.op  = DP_F_DONE;
					state_d = S_IDLE;
				end else begin
					cmd.op  = DP_READ_NXT;
					state_d = S_M_EVAL;
				end
			end
			S_M_EVAL: begin
				cmd.op  = stat.adj ? DP_M_MERGE : DP_M_ADVANCE;
				state_d = S_M_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/ffa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_datapath
// List pointers, header registers, header memory and result register.
// ----------------------------------------------------------------------------
module ffa_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ffa_pkg::ffa_in_t   request,
	input  ffa_pkg::ffa_cmd_t  cmd,
	output ffa_pkg::ffa_stat_t stat,
	output logic               done,
	output ffa_pkg::ffa_out_t  response
);
	import ffa_pkg::*;

	logic [PTR_W-1:0] free_head_q, busy_head_q, heap_top_q;
	logic [11:0]      req_q;
	logic [11:0]      daddr_q;
	logic [PTR_W-1:0] cur_q, prev_q;
	ffa_hdr_t         cur_hdr_q, prev_hdr_q, rhdr;
	logic [HDR_W-1:0] rdata;
	logic             we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	ffa_hdr_t         wdata;
	logic [PTR_W-1:0] target;
	logic [SUM_W-1:0] cur_end, carve_end;
	logic             exhaust;
	logic             done_q;
	ffa_out_t         resp_q;

	assign rhdr      = ffa_hdr_t'(rdata);
	assign target    = PTR_W'(daddr_q) - PTR_W'(HEADER_BYTES);
	assign cur_end   = SUM_W'(cur_q) + SUM_W'(cur_hdr_q.size) + SUM_W'(HEADER_BYTES);
	assign carve_end = SUM_W'(heap_top_q) + SUM_W'(req_q) + SUM_W'(HEADER_BYTES);
	assign exhaust   = carve_end > SUM_W'(HEAP_BYTES);

	assign stat.cur_null = (cur_q == NIL);
	assign stat.nxt_null = (cur_hdr_q.next_free == NIL);
	assign stat.fit      = !rhdr.busy && (rhdr.size >= req_q);
	assign stat.hit      = (cur_q == target);
	assign stat.adj      = (cur_end == SUM_W'(cur_hdr_q.next_free));
	assign stat.addr_bad = (daddr_q < 12'(HEADER_BYTES));

	// Header memory port steering
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = cur_q[ADDR_W-1:0];
		raddr = cur_q[ADDR_W-1:0];
		wdata = cur_hdr_q;
		case (cmd.op)
			DP_READ_CUR: re = 1'b1;
			DP_READ_NXT: begin
				re    = 1'b1;
				raddr = cur_hdr_q.next_free[ADDR_W-1:0];
			end
			DP_A_UNLINK: begin
				we              = (prev_q != NIL);
				waddr           = prev_q[ADDR_W-1:0];
				wdata           = prev_hdr_q;
				wdata.next_free = rhdr.next_free;
			end
			DP_A_PUSH: begin
				we              = 1'b1;
				wdata.busy      = 1'b1;
				wdata.next_busy = busy_head_q;
			end
			DP_A_CARVE: begin
				we              = !exhaust;
				waddr           = heap_top_q[ADDR_W-1:0];
				wdata.busy      = 1'b1;
				wdata.size      = req_q;
				wdata.next_free = NIL;
				wdata.next_busy = busy_head_q;
			end
			DP_F_UNLINK: begin
				we              = (prev_q != NIL);
				waddr           = prev_q[ADDR_W-1:0];
				wdata           = prev_hdr_q;
				wdata.next_busy = rhdr.next_busy;
			end
			DP_F_PUSH: begin
				we              = 1'b1;
				wdata.busy      = 1'b0;
				wdata.next_free = free_head_q;
			end
			DP_M_MERGE: begin
				we              = 1'b1;
				wdata.size      = 12'(cur_end[11:0] - cur_q[11:0] + rhdr.size);
				wdata.next_free = rhdr.next_free;
			end
			default: ;
		endcase
	end

	ffa_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_BYTES)) u_hdr_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= NIL;
			busy_head_q <= NIL;
			heap_top_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				DP_A_UNLINK: begin
					if (prev_q == NIL) begin
						free_head_q <= rhdr.next_free;
					end
				end
				DP_A_PUSH: begin
					busy_head_q <= cur_q;
					done_q      <= 1'b1;
				end
				DP_A_CARVE: begin
					if (!exhaust) begin
						busy_head_q <= heap_top_q;
						heap_top_q  <= carve_end[PTR_W-1:0];
					end
					done_q <= 1'b1;
				end
				DP_F_UNLINK: begin
					if (prev_q == NIL) begin
						busy_head_q <= rhdr.next_busy;
					end
				end
				DP_F_PUSH: free_head_q <= cur_q;
				DP_FAIL:   done_q      <= 1'b1;
				DP_F_DONE: done_q      <= 1'b1;
				default: ;
			endcase
		end
	end

	// Walk registers and result payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				req_q   <= request.request_bytes;
				daddr_q <= request.data_address;
				cur_q   <= (request.opcode == OP_FREE) ? busy_head_q : free_head_q;
				prev_q  <= NIL;
			end
			DP_A_ADVANCE: begin
				prev_q     <= cur_q;
				prev_hdr_q <= rhdr;
				cur_q      <= rhdr.next_free;
			end
			DP_F_ADVANCE: begin
				prev_q     <= cur_q;
				prev_hdr_q <= rhdr;
				cur_q      <= rhdr.next_busy;
			end
			DP_A_UNLINK, DP_F_UNLINK: cur_hdr_q <= rhdr;
			DP_A_PUSH: begin
				resp_q.result_address <= 12'(cur_q[11:0] + 12'(HEADER_BYTES));
				resp_q.status         <= ST_OK;
			end
			DP_A_CARVE: begin
				resp_q.result_address <= exhaust ? '0
					: 12'(heap_top_q[11:0] + 12'(HEADER_BYTES));
				resp_q.status         <= exhaust ? ST_EXHAUSTED : ST_OK;
			end
			DP_F_PUSH: begin
				cur_hdr_q.busy      <= 1'b0;
				cur_hdr_q.next_free <= free_head_q;
			end
			DP_M_MERGE: begin
				cur_hdr_q.size      <= 12'(cur_end[11:0] - cur_q[11:0] + rhdr.size);
				cur_hdr_q.next_free <= rhdr.next_free;
			end
			DP_M_ADVANCE: begin
				cur_q     <= cur_hdr_q.next_free;
				cur_hdr_q <= rhdr;
			end
			DP_FAIL: begin
				resp_q.result_address <= '0;
				resp_q.status         <= ST_BAD_FREE;
			end
			DP_F_DONE: begin
				resp_q.result_address <= '0;
				resp_q.status         <= ST_OK;
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign response = resp_q;

endmodule

// ----- rtl/ffa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level assertions for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_port_props (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ffa_pkg::ffa_out_t response
);
	import ffa_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("walk ended without result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.status != ST_OK) |-> (response.result_address == '0))
		else $error("error result carries an address");

endmodule

bind first_fit_block_allocator ffa_port_props u_ffa_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.response (response)
);
